// ----- rtl/core/bppc_pkg.sv -----
package bppc_pkg;

    // register index codes
    localparam logic [2:0] RegGainYaw  = 3'd0;
    localparam logic [2:0] RegGainX    = 3'd1;
    localparam logic [2:0] RegGainY    = 3'd2;
    localparam logic [2:0] RegLimitAng = 3'd3;
    localparam logic [2:0] RegLimitX   = 3'd4;
    localparam logic [2:0] RegLimitY   = 3'd5;

    localparam logic signed [19:0] PiQ16    = 20'sd205887;
    localparam logic signed [19:0] TwoPiQ16 = 20'sd411775;
    localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
    localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
    localparam logic signed [35:0] OneQ30    = 36'sd1073741824;
    localparam logic signed [35:0] KinvQ30   = 36'sd652032874;

    typedef logic signed [35:0] t_cq;

    function automatic t_cq atan_q30(input logic [4:0] idx);
        case (idx)
            5'd0: atan_q30 = 36'h03243F6A8;
            5'd1: atan_q30 = 36'h01DAC6705;
            5'd2: atan_q30 = 36'h00FADBAFC;
            5'd3: atan_q30 = 36'h007F56EA6;
            5'd4: atan_q30 = 36'h003FEAB76;
            5'd5: atan_q30 = 36'h001FFD55B;
            5'd6: atan_q30 = 36'h000FFFAAA;
            5'd7: atan_q30 = 36'h0007FFF55;
            5'd8: atan_q30 = 36'h0003FFFEA;
            5'd9: atan_q30 = 36'h0001FFFFD;
            5'd10: atan_q30 = 36'h0000FFFFF;
            5'd11: atan_q30 = 36'h00007FFFF;
            5'd12: atan_q30 = 36'h00003FFFF;
            5'd13: atan_q30 = 36'h00001FFFF;
            5'd14: atan_q30 = 36'h00000FFFF;
            5'd15: atan_q30 = 36'h000007FFF;
            5'd16: atan_q30 = 36'h000003FFF;
            5'd17: atan_q30 = 36'h000001FFF;
            5'd18: atan_q30 = 36'h000000FFF;
            5'd19: atan_q30 = 36'h0000007FF;
            5'd20: atan_q30 = 36'h0000003FF;
            5'd21: atan_q30 = 36'h0000001FF;
            5'd22: atan_q30 = 36'h0000000FF;
            5'd23: atan_q30 = 36'h00000007F;
            5'd24: atan_q30 = 36'h00000003F;
            5'd25: atan_q30 = 36'h00000001F;
            5'd26: atan_q30 = 36'h00000000F;
            5'd27: atan_q30 = 36'h000000008;
            5'd28: atan_q30 = 36'h000000004;
            5'd29: atan_q30 = 36'h000000002;
            5'd30: atan_q30 = 36'h000000001;
            default: atan_q30 = '0;
        endcase
    endfunction

    // item context carried alongside the CORDIC
    typedef struct packed {
        logic signed [32:0] ex;
        logic signed [32:0] ey;
        logic signed [19:0] eyaw;
        logic               yaw_ok;
        logic               goto_mode;
    } t_ctx;

endpackage

// ----- rtl/core/base_pose_p_controller.sv -----
// channel | dir | handshake            | payload
// cfg     | in  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
// pose    | in  | i_valid/o_ready      | pose, goal, valid flags, clamp mode
// cmd     | out | o_valid/i_ready      | velocities, publish, limit_exceeded
// One item per cycle while the output is free or being taken. Stages in order: fold, one CORDIC
// stage per register, clamp, two rotate-product stages, gain, limit/output.
// Synchronous active-low reset clears valid bits and loads default gains/limits.
// The whole pipe advances when the output register is free or being taken;
// a stall freezes every stage, so nothing is lost or repeated.
module base_pose_p_controller #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_pose_x,
    input  logic signed [31:0] i_pose_y,
    input  logic signed [18:0] i_pose_yaw,
    input  logic signed [31:0] i_goal_x,
    input  logic signed [31:0] i_goal_y,
    input  logic signed [18:0] i_goal_yaw,
    input  logic               i_goal_x_valid,
    input  logic               i_goal_y_valid,
    input  logic               i_goal_yaw_valid,
    input  logic               i_clamp_mode,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_vel_x,
    output logic signed [31:0] o_vel_y,
    output logic signed [31:0] o_vel_ang,
    output logic               o_publish,
    output logic               o_limit_exceeded
);
    localparam int N = CORDIC_STAGES;

    logic [15:0] r_gain_yaw, r_gain_x, r_gain_y;
    logic [30:0] r_lim_ang, r_lim_x, r_lim_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_yaw <= 16'd205;
            r_gain_x   <= 16'd315;
            r_gain_y   <= 16'd315;
            r_lim_ang  <= 31'd32768;
            r_lim_x    <= 31'd32768;
            r_lim_y    <= 31'd32768;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bppc_pkg::RegGainYaw:  r_gain_yaw <= i_cfg_data[15:0];
                bppc_pkg::RegGainX:    r_gain_x   <= i_cfg_data[15:0];
                bppc_pkg::RegGainY:    r_gain_y   <= i_cfg_data[15:0];
                bppc_pkg::RegLimitAng: r_lim_ang  <= i_cfg_data[30:0];
                bppc_pkg::RegLimitX:   r_lim_x    <= i_cfg_data[30:0];
                bppc_pkg::RegLimitY:   r_lim_y    <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    logic adv;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    // CORDIC pipe; entry 0 is the fold stage register
    logic               rc_v    [N+1];
    bppc_pkg::t_ctx     rc_ctx  [N+1];
    bppc_pkg::t_cq      rc_x    [N+1];
    bppc_pkg::t_cq      rc_y    [N+1];
    bppc_pkg::t_cq      rc_z    [N+1];
    logic               rc_flip [N+1];

    // stage 0: errors, yaw wrap, CORDIC fold
    bppc_pkg::t_ctx     n0_ctx;
    bppc_pkg::t_cq      n0_z;
    logic               n0_flip;
    logic signed [19:0] e0;

    always_comb begin
        e0 = 20'(i_goal_yaw) - 20'(i_pose_yaw);
        if (e0 > bppc_pkg::PiQ16) e0 = e0 - bppc_pkg::TwoPiQ16;
        if (e0 < -bppc_pkg::PiQ16) e0 = e0 + bppc_pkg::TwoPiQ16;
        n0_ctx.eyaw      = e0;
        n0_ctx.yaw_ok    = i_goal_yaw_valid;
        n0_ctx.goto_mode = i_clamp_mode;
        n0_ctx.ex = i_goal_x_valid ? 33'(i_goal_x) - 33'(i_pose_x) : '0;
        n0_ctx.ey = i_goal_y_valid ? 33'(i_goal_y) - 33'(i_pose_y) : '0;
        n0_z      = 36'(i_pose_yaw) <<< 14;
        n0_flip   = 1'b0;
        if (n0_z > bppc_pkg::HalfPiQ30) begin
            n0_z = n0_z - bppc_pkg::PiQ30; n0_flip = 1'b1;
        end else if (n0_z < -bppc_pkg::HalfPiQ30) begin
            n0_z = n0_z + bppc_pkg::PiQ30; n0_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rc_v[0] <= 1'b0;
        else if (adv) rc_v[0] <= i_valid;
        if (adv) begin
            rc_ctx[0]  <= n0_ctx;
            rc_x[0]    <= bppc_pkg::KinvQ30;
            rc_y[0]    <= '0;
            rc_z[0]    <= n0_z;
            rc_flip[0] <= n0_flip;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cordic
        bppc_pkg::t_cq n_x, n_y, n_z;
        always_comb begin
            if (!rc_z[g][35]) begin
                n_x = rc_x[g] - (rc_y[g] >>> g);
                n_y = rc_y[g] + (rc_x[g] >>> g);
                n_z = rc_z[g] - bppc_pkg::atan_q30(5'(g));
            end else begin
                n_x = rc_x[g] + (rc_y[g] >>> g);
                n_y = rc_y[g] - (rc_x[g] >>> g);
                n_z = rc_z[g] + bppc_pkg::atan_q30(5'(g));
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) rc_v[g+1] <= 1'b0;
            else if (adv) rc_v[g+1] <= rc_v[g];
            if (adv) begin
                rc_ctx[g+1]  <= rc_ctx[g];
                rc_x[g+1]    <= n_x;
                rc_y[g+1]    <= n_y;
                rc_z[g+1]    <= n_z;
                rc_flip[g+1] <= rc_flip[g];
            end
        end
    end

    // stage A: flip and clamp to +-1
    logic               ra_v;
    bppc_pkg::t_ctx     ra_ctx;
    logic signed [31:0] ra_c, ra_s;
    bppc_pkg::t_cq      na_c, na_s;
    always_comb begin
        na_c = rc_flip[N] ? -rc_x[N] : rc_x[N];
        na_s = rc_flip[N] ? -rc_y[N] : rc_y[N];
        if (na_c > bppc_pkg::OneQ30) na_c = bppc_pkg::OneQ30;
        if (na_c < -bppc_pkg::OneQ30) na_c = -bppc_pkg::OneQ30;
        if (na_s > bppc_pkg::OneQ30) na_s = bppc_pkg::OneQ30;
        if (na_s < -bppc_pkg::OneQ30) na_s = -bppc_pkg::OneQ30;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) ra_v <= 1'b0;
        else if (adv) ra_v <= rc_v[N];
        if (adv) begin
            ra_ctx <= rc_ctx[N];
            ra_c   <= 32'(na_c);
            ra_s   <= 32'(na_s);
        end
    end

    // stage B: four rotation products
    logic           rb_v;
    bppc_pkg::t_ctx rb_ctx;
    logic signed [64:0] rb_cx, rb_sy, rb_cy, rb_sx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rb_v <= 1'b0;
        else if (adv) rb_v <= ra_v;
        if (adv) begin
            rb_ctx <= ra_ctx;
            rb_cx  <= ra_c * ra_ctx.ex;
            rb_sy  <= ra_s * ra_ctx.ey;
            rb_cy  <= ra_c * ra_ctx.ey;
            rb_sx  <= ra_s * ra_ctx.ex;
        end
    end

    // stage C: sum and round to robot-frame errors
    logic               rcc_v;
    bppc_pkg::t_ctx     rcc_ctx;
    logic signed [35:0] rcc_erx, rcc_ery;
    logic signed [66:0] sx, sy;
    always_comb begin
        sx = 67'(rb_cx) + 67'(rb_sy) + 67'sd536870912;
        sy = 67'(rb_cy) - 67'(rb_sx) + 67'sd536870912;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rcc_v <= 1'b0;
        else if (adv) rcc_v <= rb_v;
        if (adv) begin
            rcc_ctx <= rb_ctx;
            rcc_erx <= 36'(sx >>> 30);
            rcc_ery <= 36'(sy >>> 30);
        end
    end

    // stage D: gain products
    logic               rd_v;
    bppc_pkg::t_ctx     rd_ctx;
    logic signed [52:0] rd_px, rd_py;
    logic signed [36:0] rd_pa;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rd_v <= 1'b0;
        else if (adv) rd_v <= rcc_v;
        if (adv) begin
            rd_ctx <= rcc_ctx;
            rd_px  <= rcc_erx * $signed({1'b0, r_gain_x});
            rd_py  <= rcc_ery * $signed({1'b0, r_gain_y});
            rd_pa  <= rcc_ctx.eyaw * $signed({1'b0, r_gain_yaw});
        end
    end

    // stage E: round, limit, saturate
    logic signed [44:0] vx, vy, va, ox, oy, oa;
    logic signed [44:0] lx, ly, la;
    logic               exc;

    function automatic logic signed [44:0] sat32(input logic signed [44:0] v);
        if (v > 45'sd2147483647) sat32 = 45'sd2147483647;
        else if (v < -45'sd2147483648) sat32 = -45'sd2147483648;
        else sat32 = v;
    endfunction

    always_comb begin
        lx = $signed(45'(r_lim_x));
        ly = $signed(45'(r_lim_y));
        la = $signed(45'(r_lim_ang));
        vx = 45'((rd_px + 53'sd128) >>> 8);
        vy = 45'((rd_py + 53'sd128) >>> 8);
        va = rd_ctx.yaw_ok ? 45'((rd_pa + 37'sd128) >>> 8) : '0;
        exc = 1'b0;
        ox = vx; oy = vy; oa = va;
        if (vx > lx || vx < -lx) begin
            if (rd_ctx.goto_mode) ox = vx[44] ? -lx : lx;
            else exc = 1'b1;
        end
        if (vy > ly || vy < -ly) begin
            if (rd_ctx.goto_mode) oy = vy[44] ? -ly : ly;
            else exc = 1'b1;
        end
        if (va > la || va < -la) begin
            if (rd_ctx.goto_mode) oa = va[44] ? -la : la;
            else exc = 1'b1;
        end
        ox = sat32(ox); oy = sat32(oy); oa = sat32(oa);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (adv) o_valid <= rd_v;
        if (adv) begin
            o_vel_x          <= ox[31:0];
            o_vel_y          <= oy[31:0];
            o_vel_ang        <= oa[31:0];
            o_publish        <= !exc;
            o_limit_exceeded <= exc;
        end
    end
endmodule

// ----- rtl/core/bppc_checker.sv -----
module bppc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_publish,
    input logic        o_limit_exceeded,
    input logic [31:0] o_vel_x
);
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_publish != o_limit_exceeded)) else $error("flag mismatch");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_vel_x)) else $error("out hold");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready) else $error("not ready while empty");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready) else $error("accept during stall");
endmodule

bind base_pose_p_controller bppc_checker u_bppc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_publish(o_publish),
    .o_limit_exceeded(o_limit_exceeded), .o_vel_x(o_vel_x)
);
